FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker xyzrmse_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define XR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define XR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/xyzrmse_pkg.sv
// ----------------------------------------------------------------------------
// xyzrmse_pkg
// Shared widths, register map, job codes, color matrix and bus structs.
// ----------------------------------------------------------------------------
package xyzrmse_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int REG_W    = 13;
    localparam int CMP_W    = ((CNT_W > REG_W) ? CNT_W : REG_W) + 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int BYTE_W   = 8;
    localparam int COEF_W   = 16;
    localparam int ACC_W    = 25;
    localparam int XYZ_W    = 17;
    localparam int SQ_W     = 34;
    localparam int SUM_W    = 58;
    localparam int PEAK_W   = 36;
    localparam int N_W      = 2 * REG_W;
    localparam int DVD_W    = 60;
    localparam int DVS_W    = 28;
    localparam int ROOT_W   = DVD_W / 2;
    localparam int OUT_W    = 17;
    localparam int NUM_JOBS = 5;
    localparam int JOB_W    = 3;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
    localparam logic [REG_W-1:0] START_OFF = {REG_W{1'b1}};

    // register indexes
    localparam logic [2:0] REG_X_START = 3'd0;
    localparam logic [2:0] REG_Y_START = 3'd1;
    localparam logic [2:0] REG_WIN_W   = 3'd2;
    localparam logic [2:0] REG_WIN_H   = 3'd3;
    localparam logic [2:0] REG_FRM_W   = 3'd4;
    localparam logic [2:0] REG_FRM_H   = 3'd5;

    // frame-end jobs, in result order
    localparam logic [JOB_W-1:0] JOB_X    = 3'd0;
    localparam logic [JOB_W-1:0] JOB_Y    = 3'd1;
    localparam logic [JOB_W-1:0] JOB_Z    = 3'd2;
    localparam logic [JOB_W-1:0] JOB_TOT  = 3'd3;
    localparam logic [JOB_W-1:0] JOB_PEAK = 3'd4;

    // sRGB to XYZ, Q0.16, row major
    localparam logic [COEF_W-1:0] XYZ_COEF [9] = '{
        16'd27031, 16'd23434, 16'd11825,
        16'd13938, 16'd46868, 16'd4730,
        16'd1267,  16'd7811,  16'd62279
    };

    typedef struct packed {
        logic [REG_W-1:0] x_start;
        logic [REG_W-1:0] y_start;
        logic [REG_W-1:0] win_width;
        logic [REG_W-1:0] win_height;
        logic [REG_W-1:0] frame_width;
        logic [REG_W-1:0] frame_height;
    } t_cfg;

    typedef struct packed {
        logic             take;
        logic             div_start;
        logic             sqrt_start;
        logic             store;
        logic [JOB_W-1:0] job;
        logic             load_out;
        logic             clear;
    } t_cmd;

    typedef struct packed {
        logic pipe_empty;
        logic div_done;
        logic sqrt_done;
        logic out_full;
    } t_stat;

    // one XYZ component, rounded half up, Q9.8
    function automatic logic [XYZ_W-1:0] to_xyz(input int row, input logic [BYTE_W-1:0] r,
                                                 input logic [BYTE_W-1:0] g,
                                                 input logic [BYTE_W-1:0] b);
        logic [ACC_W-1:0] acc;
        acc = ACC_W'(XYZ_COEF[3*row])   * ACC_W'(r)
            + ACC_W'(XYZ_COEF[3*row+1]) * ACC_W'(g)
            + ACC_W'(XYZ_COEF[3*row+2]) * ACC_W'(b)
            + ACC_W'(128);
        return acc[ACC_W-1:8];
    endfunction

endpackage

FILE: rtl/xyz_image_rmse_accumulator.sv
// ----------------------------------------------------------------------------
// xyz_image_rmse_accumulator
// Per-frame XYZ RMSE of a test image against a reference image.
// ----------------------------------------------------------------------------
// Pixel pairs stream in raster order, one transfer per cycle while a frame is
// running. Each pixel is converted to XYZ (Q9.8) for both images, and pixels
// inside the optional window add their squared differences to 58-bit
// saturating sums; the largest per-pixel sum of squares is kept as the peak.
// The transfer flagged last_pixel closes the frame: input ready drops while
// the pipeline drains and five results are worked out one after the other
// on a shared restoring divider and a shared square root unit. The results
// go to an output register; the next frame's pixels are taken while it
// waits to be read, and a second frame end waits for it to empty. Sums and
// the peak clear when the result is posted; the position counters clear
// with the last pixel. Registers sit on an APB port at 4*index and take
// effect for pixels that follow the write; write them only between frames.
// ----------------------------------------------------------------------------
module xyz_image_rmse_accumulator import xyzrmse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // pixel input
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_test_r,
    input  logic [BYTE_W-1:0] i_test_g,
    input  logic [BYTE_W-1:0] i_test_b,
    input  logic [BYTE_W-1:0] i_ref_r,
    input  logic [BYTE_W-1:0] i_ref_g,
    input  logic [BYTE_W-1:0] i_ref_b,
    input  logic              i_last_pixel,
    // frame results
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_rmse_x,
    output logic [OUT_W-1:0]  o_rmse_y,
    output logic [OUT_W-1:0]  o_rmse_z,
    output logic [OUT_W-1:0]  o_rmse_total,
    output logic [OUT_W-1:0]  o_peak_rms
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    // register file
    xyzrmse_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: owns input ready and the frame-end job order
    xyzrmse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_pixel (i_last_pixel),
        .o_ready      (o_ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // pixel pipe, sums, divider, root and output register
    xyzrmse_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_test_r     (i_test_r),
        .i_test_g     (i_test_g),
        .i_test_b     (i_test_b),
        .i_ref_r      (i_ref_r),
        .i_ref_g      (i_ref_g),
        .i_ref_b      (i_ref_b),
        .i_last_pixel (i_last_pixel),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_rmse_x     (o_rmse_x),
        .o_rmse_y     (o_rmse_y),
        .o_rmse_z     (o_rmse_z),
        .o_rmse_total (o_rmse_total),
        .o_peak_rms   (o_peak_rms)
    );

endmodule

FILE: rtl/xyzrmse_regs.sv
// ----------------------------------------------------------------------------
// xyzrmse_regs
// APB register file for the window and frame settings.
// ----------------------------------------------------------------------------
module xyzrmse_regs import xyzrmse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_start      <= START_OFF;
            r_cfg.y_start      <= START_OFF;
            r_cfg.win_width    <= REG_W'(1);
            r_cfg.win_height   <= REG_W'(1);
            r_cfg.frame_width  <= REG_W'(1);
            r_cfg.frame_height <= REG_W'(1);
        end else if (wr) begin
            case (idx)
                REG_X_START: r_cfg.x_start      <= pwdata[REG_W-1:0];
                REG_Y_START: r_cfg.y_start      <= pwdata[REG_W-1:0];
                REG_WIN_W:   r_cfg.win_width    <= pwdata[REG_W-1:0];
                REG_WIN_H:   r_cfg.win_height   <= pwdata[REG_W-1:0];
                REG_FRM_W:   r_cfg.frame_width  <= pwdata[REG_W-1:0];
                REG_FRM_H:   r_cfg.frame_height <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_X_START: prdata = DATA_W'(r_cfg.x_start);
            REG_Y_START: prdata = DATA_W'(r_cfg.y_start);
            REG_WIN_W:   prdata = DATA_W'(r_cfg.win_width);
            REG_WIN_H:   prdata = DATA_W'(r_cfg.win_height);
            REG_FRM_W:   prdata = DATA_W'(r_cfg.frame_width);
            REG_FRM_H:   prdata = DATA_W'(r_cfg.frame_height);
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: rtl/xyzrmse_div.sv
// ----------------------------------------------------------------------------
// xyzrmse_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xyzrmse_div import xyzrmse_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quot,
    output logic             o_done
);

    localparam int DC_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [DC_W-1:0]   r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_d;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              ge;

    assign rem_sh  = {r_rem, r_q[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_d};
    assign rem_sub = rem_sh - {1'b0, r_d};
    assign o_quot  = r_q;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DC_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_d   <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

endmodule

FILE: rtl/xyzrmse_sqrt.sv
// ----------------------------------------------------------------------------
// xyzrmse_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module xyzrmse_sqrt import xyzrmse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_val,
    output logic [ROOT_W-1:0] o_root,
    output logic              o_done
);

    localparam int SC_W  = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [SC_W-1:0]   r_cnt;
    logic [DVD_W-1:0]  r_v;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    assign rem_sh = {r_rem, r_v[DVD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({r_root, 2'b01});
    assign ge     = rem_sh >= trial;
    assign o_root = r_root;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SC_W'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[DVD_W-3:0], 2'b00};
            r_rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

endmodule

FILE: rtl/xyzrmse_dp.sv
// ----------------------------------------------------------------------------
// xyzrmse_dp
// Pixel pipeline, accumulators, frame-end divide and root, result registers.
// ----------------------------------------------------------------------------
module xyzrmse_dp import xyzrmse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [BYTE_W-1:0] i_test_r,
    input  logic [BYTE_W-1:0] i_test_g,
    input  logic [BYTE_W-1:0] i_test_b,
    input  logic [BYTE_W-1:0] i_ref_r,
    input  logic [BYTE_W-1:0] i_ref_g,
    input  logic [BYTE_W-1:0] i_ref_b,
    input  logic              i_last_pixel,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_rmse_x,
    output logic [OUT_W-1:0]  o_rmse_y,
    output logic [OUT_W-1:0]  o_rmse_z,
    output logic [OUT_W-1:0]  o_rmse_total,
    output logic [OUT_W-1:0]  o_peak_rms
);

    // position and window test
    logic [CNT_W-1:0]        r_col, r_row;
    logic signed [CMP_W-1:0] col_s, row_s, xs, ys, xe, ye, row_len;
    logic                    xon, yon, use_px, row_end;

    assign col_s   = CMP_W'(r_col);
    assign row_s   = CMP_W'(r_row);
    assign xs      = CMP_W'(signed'(i_cfg.x_start));
    assign ys      = CMP_W'(signed'(i_cfg.y_start));
    assign xe      = xs + CMP_W'(i_cfg.win_width);
    assign ye      = ys + CMP_W'(i_cfg.win_height);
    assign xon     = i_cfg.x_start != START_OFF;
    assign yon     = i_cfg.y_start != START_OFF;
    assign use_px  = (!xon || (col_s >= xs && col_s < xe))
                  && (!yon || (row_s >= ys && row_s < ye));
    assign row_len = (CMP_W'(i_cfg.frame_width) < CMP_W'(MAX_DIM))
                   ? CMP_W'(i_cfg.frame_width) : CMP_W'(MAX_DIM);
    assign row_end = (col_s + CMP_W'(1)) >= row_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.take) begin
            if (i_last_pixel) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= (r_row == CNT_W'(MAX_DIM - 1)) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage A: input capture
    logic              r_a_v, r_a_use;
    logic [BYTE_W-1:0] r_a_t [3];
    logic [BYTE_W-1:0] r_a_r [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_cmd.take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_a_use <= use_px;
            r_a_t[0] <= i_test_r;
            r_a_t[1] <= i_test_g;
            r_a_t[2] <= i_test_b;
            r_a_r[0] <= i_ref_r;
            r_a_r[1] <= i_ref_g;
            r_a_r[2] <= i_ref_b;
        end
    end

    // stage B: XYZ, stage C: squared differences
    logic             r_b_v, r_b_use, r_c_v, r_c_use;
    logic [XYZ_W-1:0] r_b_t [3];
    logic [XYZ_W-1:0] r_b_r [3];
    logic [SQ_W-1:0]  r_c_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_use <= r_a_use;
        r_c_use <= r_b_use;
    end

    for (genvar k = 0; k < 3; k++) begin : g_ch
        logic signed [XYZ_W:0]     diff;
        logic signed [2*XYZ_W+1:0] prod;

        assign diff = signed'({1'b0, r_b_t[k]}) - signed'({1'b0, r_b_r[k]});
        assign prod = diff * diff;

        always_ff @(posedge i_clk) begin
            r_b_t[k]  <= to_xyz(k, r_a_t[0], r_a_t[1], r_a_t[2]);
            r_b_r[k]  <= to_xyz(k, r_a_r[0], r_a_r[1], r_a_r[2]);
            r_c_sq[k] <= prod[SQ_W-1:0];
        end
    end

    // accumulation
    logic [SUM_W-1:0]  r_sum [3];
    logic [PEAK_W-1:0] r_peak;
    logic [PEAK_W-1:0] px;

    assign px = PEAK_W'(r_c_sq[0]) + PEAK_W'(r_c_sq[1]) + PEAK_W'(r_c_sq[2]);

    for (genvar k = 0; k < 3; k++) begin : g_acc
        logic [SUM_W:0] s;
        assign s = {1'b0, r_sum[k]} + (SUM_W+1)'(r_c_sq[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.clear) begin
                r_sum[k] <= '0;
            end else if (r_c_v && r_c_use) begin
                r_sum[k] <= s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_peak <= '0;
        end else if (r_c_v && r_c_use && px > r_peak) begin
            r_peak <= px;
        end
    end

    // frame-end divisor: window area only with both starts set
    logic [N_W-1:0] r_n;
    always_ff @(posedge i_clk) begin
        r_n <= (xon && yon) ? N_W'(i_cfg.win_width) * N_W'(i_cfg.win_height)
                            : N_W'(i_cfg.frame_width) * N_W'(i_cfg.frame_height);
    end

    logic [DVD_W-1:0]  dvd, quot;
    logic [DVS_W-1:0]  dvs;
    logic [ROOT_W-1:0] root;
    logic              div_done, sqrt_done;

    always_comb begin
        case (i_cmd.job)
            JOB_X:    begin dvd = DVD_W'(r_sum[0]); dvs = DVS_W'(r_n); end
            JOB_Y:    begin dvd = DVD_W'(r_sum[1]); dvs = DVS_W'(r_n); end
            JOB_Z:    begin dvd = DVD_W'(r_sum[2]); dvs = DVS_W'(r_n); end
            JOB_TOT:  begin
                dvd = DVD_W'(r_sum[0]) + DVD_W'(r_sum[1]) + DVD_W'(r_sum[2]);
                dvs = (DVS_W'(r_n) << 1) + DVS_W'(r_n);
            end
            JOB_PEAK: begin dvd = DVD_W'(r_peak); dvs = DVS_W'(3); end
            default:  begin dvd = '0; dvs = '0; end
        endcase
    end

    xyzrmse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    xyzrmse_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (quot),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    // result staging and output register
    logic [OUT_W-1:0] r_res [NUM_JOBS];
    logic             r_out_v;
    logic [OUT_W-1:0] r_o [NUM_JOBS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_res[i_cmd.job] <= (root > ROOT_W'(OUT_MAX)) ? OUT_MAX : root[OUT_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_o <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid      = r_out_v;
    assign o_rmse_x     = r_o[JOB_X];
    assign o_rmse_y     = r_o[JOB_Y];
    assign o_rmse_z     = r_o[JOB_Z];
    assign o_rmse_total = r_o[JOB_TOT];
    assign o_peak_rms   = r_o[JOB_PEAK];

    assign o_stat.pipe_empty = !(r_a_v || r_b_v || r_c_v);
    assign o_stat.div_done   = div_done;
    assign o_stat.sqrt_done  = sqrt_done;
    assign o_stat.out_full   = r_out_v;

endmodule

FILE: rtl/xyzrmse_ctrl.sv
// ----------------------------------------------------------------------------
// xyzrmse_ctrl
// Frame sequencer: pixel intake, then five divide and root jobs.
// ----------------------------------------------------------------------------
module xyzrmse_ctrl import xyzrmse_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last_pixel,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_RUN     = 3'd0;
    localparam logic [2:0] S_DRAIN   = 3'd1;
    localparam logic [2:0] S_DIV_GO  = 3'd2;
    localparam logic [2:0] S_DIV_W   = 3'd3;
    localparam logic [2:0] S_SQ_GO   = 3'd4;
    localparam logic [2:0] S_SQ_W    = 3'd5;
    localparam logic [2:0] S_STORE   = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [JOB_W-1:0] r_job, n_job;
    logic             take;

    assign o_ready = r_state == S_RUN;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        o_cmd   = '0;
        o_cmd.take = take;
        o_cmd.job  = r_job;
        case (r_state)
            S_RUN: begin
                if (take && i_last_pixel) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_job = JOB_X;
                if (i_stat.pipe_empty) n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_W;
            end
            S_DIV_W: begin
                if (i_stat.div_done) n_state = S_SQ_GO;
            end
            S_SQ_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQ_W;
            end
            S_SQ_W: begin
                if (i_stat.sqrt_done) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_job == JOB_PEAK) begin
                    n_state = S_OUT;
                end else begin
                    n_job   = r_job + 1'b1;
                    n_state = S_DIV_GO;
                end
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_job   <= JOB_X;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

endmodule

FILE: rtl/xyzrmse_chk.sv
// ----------------------------------------------------------------------------
// xyzrmse_chk
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xyzrmse_chk import xyzrmse_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              pready,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_last_pixel,
    input logic              o_valid,
    input logic              i_ready,
    input logic [OUT_W-1:0]  o_rmse_total,
    input logic [OUT_W-1:0]  o_peak_rms
);

    `XR_ASSERT(a_hold_valid, o_valid && !i_ready |=> o_valid, "result dropped while stalled")
    `XR_ASSERT(a_hold_data, o_valid && !i_ready |=> $stable(o_rmse_total) && $stable(o_peak_rms), "result changed while stalled")
    `XR_ASSERT(a_last_stall, i_valid && o_ready && i_last_pixel |=> !o_ready, "pixel taken during frame-end work")
    `XR_ASSERT(a_pready, pready, "pready low")
    `XR_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind xyz_image_rmse_accumulator xyzrmse_chk u_chk (.*);
